>>> sv/rdsc_pkg.sv
// ----------------------------------------------------------------------------
// rdsc_pkg
// shared types, constants and the digit glyph lookup of the radix digit
// string converter
// ----------------------------------------------------------------------------
package rdsc_pkg;

    localparam int NUMBER_WIDTH_DEF = 32;
    localparam int MAX_DIGITS_DEF   = 32;

    localparam int RADIX_W = 6;
    localparam int DIGIT_W = 6;
    localparam int CHAR_W  = 7;

    localparam logic [RADIX_W-1:0] RADIX_RESET = 6'd10;
    localparam logic [RADIX_W-1:0] RADIX_MIN   = 6'd2;
    localparam logic [RADIX_W-1:0] RADIX_MAX   = 6'd36;

    localparam logic [CHAR_W-1:0] CHAR_ZERO   = 7'h30;
    localparam logic [CHAR_W-1:0] CHAR_LETTER = 7'h41;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIVIDE,
        ST_READ,
        ST_SHOW,
        ST_ERROR
    } conv_state_t;

    typedef struct packed {
        logic load;
        logic cont;
    } div_ctrl_t;

    typedef struct packed {
        logic               done;
        logic [DIGIT_W-1:0] digit;
        logic               zero;
    } div_status_t;

    function automatic logic [CHAR_W-1:0] digit_glyph(input logic [DIGIT_W-1:0] d);
        logic [CHAR_W-1:0] c;
        if (d < DIGIT_W'(10))
            c = CHAR_ZERO + CHAR_W'(d);
        else
            c = CHAR_LETTER + CHAR_W'(d - DIGIT_W'(10));
        return c;
    endfunction

endpackage

>>> sv/radix_digit_string_converter_core.sv
// ----------------------------------------------------------------------------
// radix_digit_string_converter_core
// converts an unsigned number to ascii digits in the configured radix,
// most significant digit first, last character marked
//
//   channel | direction | handshake           | payload
//   in      | input     | in_valid/in_ready   | number
//   out     | output    | out_valid/out_ready | digit_char, last_digit, radix_error
//   cfg     | input     | cfg_we              | cfg_wdata (radix)
//
// conversion runs a bit-serial divider: the first digit comes from a pass over all
// NUMBER_WIDTH bits, each further digit from a pass over the bits of the running quotient
// emission does a buffer read, then a show, for each digit, and holds on out stalls
// a bad radix shows its error transaction in the cycle after acceptance
// one number at a time; in_ready only while idle; reset leaves radix at 10
// ----------------------------------------------------------------------------
module radix_digit_string_converter_core
    import rdsc_pkg::*;
#(
    parameter int NUMBER_WIDTH = NUMBER_WIDTH_DEF,
    parameter int MAX_DIGITS   = MAX_DIGITS_DEF
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    cfg_we,
    input  logic [RADIX_W-1:0]      cfg_wdata,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  logic [NUMBER_WIDTH-1:0] number,
    output logic                    out_valid,
    input  logic                    out_ready,
    output logic [CHAR_W-1:0]       digit_char,
    output logic                    last_digit,
    output logic                    radix_error
);

    localparam int IW = $clog2(MAX_DIGITS);

    conv_state_t        state_reg, state_next;
    logic [IW-1:0]      wptr_reg, wptr_next;
    logic [IW-1:0]      rptr_reg, rptr_next;
    logic [RADIX_W-1:0] radix_reg;

    div_ctrl_t          div_ctrl;
    div_status_t        div_status;
    logic               buf_we;
    logic               buf_re;
    logic [DIGIT_W-1:0] buf_rdata;
    logic               radix_ok;

    assign radix_ok = (radix_reg >= RADIX_MIN) && (radix_reg <= RADIX_MAX);

    rdsc_divider #(
        .NUMBER_WIDTH (NUMBER_WIDTH)
    ) u_divider (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctrl   (div_ctrl),
        .value  (number),
        .radix  (radix_reg),
        .status (div_status)
    );

    rdsc_digit_buf #(
        .MAX_DIGITS (MAX_DIGITS)
    ) u_digit_buf (
        .clk   (clk),
        .we    (buf_we),
        .waddr (wptr_reg),
        .wdata (div_status.digit),
        .re    (buf_re),
        .raddr (rptr_reg),
        .rdata (buf_rdata)
    );

    always_comb
    begin
        state_next  = state_reg;
        wptr_next   = wptr_reg;
        rptr_next   = rptr_reg;
        div_ctrl    = '0;
        buf_we      = 1'b0;
        buf_re      = 1'b0;
        in_ready    = 1'b0;
        out_valid   = 1'b0;
        digit_char  = '0;
        last_digit  = 1'b0;
        radix_error = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    if (radix_ok)
                    begin
                        div_ctrl.load = 1'b1;
                        wptr_next     = '0;
                        state_next    = ST_DIVIDE;
                    end
                    else
                    begin
                        state_next = ST_ERROR;
                    end
                end
            end
            ST_DIVIDE:
            begin
                if (div_status.done)
                begin
                    buf_we = 1'b1;
                    // stop on zero quotient or full buffer
                    if (div_status.zero || (wptr_reg == IW'(MAX_DIGITS - 1)))
                    begin
                        rptr_next  = wptr_reg;
                        state_next = ST_READ;
                    end
                    else
                    begin
                        div_ctrl.cont = 1'b1;
                        wptr_next     = wptr_reg + IW'(1);
                    end
                end
            end
            ST_READ:
            begin
                buf_re     = 1'b1;
                state_next = ST_SHOW;
            end
            ST_SHOW:
            begin
                out_valid  = 1'b1;
                digit_char = digit_glyph(buf_rdata);
                last_digit = (rptr_reg == '0);
                if (out_ready)
                begin
                    if (rptr_reg == '0)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        rptr_next  = rptr_reg - IW'(1);
                        state_next = ST_READ;
                    end
                end
            end
            ST_ERROR:
            begin
                out_valid   = 1'b1;
                radix_error = 1'b1;
                if (out_ready)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            radix_reg <= RADIX_RESET;
        end
        else
        begin
            state_reg <= state_next;
            wptr_reg  <= wptr_next;
            rptr_reg  <= rptr_next;
            if (cfg_we)
                radix_reg <= cfg_wdata;
        end
    end

endmodule

>>> sv/rdsc_divider.sv
// ----------------------------------------------------------------------------
// rdsc_divider
// bit-serial restoring divider; one quotient bit per cycle, quotient kept in
// place, each later pass starts at the highest set bit left by the previous pass
// ----------------------------------------------------------------------------
module rdsc_divider
    import rdsc_pkg::*;
#(
    parameter int NUMBER_WIDTH = NUMBER_WIDTH_DEF
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  div_ctrl_t               ctrl,
    input  logic [NUMBER_WIDTH-1:0] value,
    input  logic [RADIX_W-1:0]      radix,
    output div_status_t             status
);

    localparam int IXW = $clog2(NUMBER_WIDTH);

    logic [NUMBER_WIDTH-1:0] q_reg, q_next;
    logic [DIGIT_W-1:0]      rem_reg, rem_next;
    logic [IXW-1:0]          idx_reg, idx_next;
    logic [IXW-1:0]          hi_reg, hi_next;
    logic                    seen_reg, seen_next;
    logic                    active_reg, active_next;

    logic [DIGIT_W:0] trial;
    logic             ge;
    logic             hit;

    always_comb
    begin
        trial = {rem_reg, q_reg[idx_reg]};
        ge    = trial >= {1'b0, radix};
        hit   = ge && !seen_reg;

        q_next      = q_reg;
        rem_next    = ge ? DIGIT_W'(trial - {1'b0, radix}) : trial[DIGIT_W-1:0];
        idx_next    = idx_reg;
        hi_next     = hit ? idx_reg : hi_reg;
        seen_next   = seen_reg || ge;
        active_next = active_reg;

        status.done  = active_reg && (idx_reg == '0);
        status.digit = rem_next;
        status.zero  = !(seen_reg || ge);

        if (ctrl.load)
        begin
            q_next      = value;
            rem_next    = '0;
            idx_next    = IXW'(NUMBER_WIDTH - 1);
            seen_next   = 1'b0;
            active_next = 1'b1;
        end
        else if (active_reg)
        begin
            q_next[idx_reg] = ge;
            if (idx_reg == '0)
            begin
                // next pass restarts at the top set bit of the new quotient
                if (ctrl.cont)
                begin
                    rem_next  = '0;
                    idx_next  = hit ? idx_reg : hi_reg;
                    seen_next = 1'b0;
                end
                else
                begin
                    active_next = 1'b0;
                end
            end
            else
            begin
                idx_next = idx_reg - IXW'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            seen_reg   <= 1'b0;
            idx_reg    <= '0;
        end
        else
        begin
            active_reg <= active_next;
            seen_reg   <= seen_next;
            idx_reg    <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg   <= q_next;
        rem_reg <= rem_next;
        hi_reg  <= hi_next;
    end

endmodule

>>> sv/rdsc_digit_buf.sv
// ----------------------------------------------------------------------------
// rdsc_digit_buf
// digit store, one write port and one registered read port
// ----------------------------------------------------------------------------
module rdsc_digit_buf
    import rdsc_pkg::*;
#(
    parameter int MAX_DIGITS = MAX_DIGITS_DEF
)
(
    input  logic                          clk,
    input  logic                          we,
    input  logic [$clog2(MAX_DIGITS)-1:0] waddr,
    input  logic [DIGIT_W-1:0]            wdata,
    input  logic                          re,
    input  logic [$clog2(MAX_DIGITS)-1:0] raddr,
    output logic [DIGIT_W-1:0]            rdata
);

    logic [DIGIT_W-1:0] mem [MAX_DIGITS];
    logic [DIGIT_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        if (re)
            rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

>>> sv/rdsc_checker.sv
// ----------------------------------------------------------------------------
// rdsc_checker
// port-level checks on the converter, bound to the top level
// ----------------------------------------------------------------------------
module rdsc_checker
    import rdsc_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              in_ready,
    input logic              out_valid,
    input logic              out_ready,
    input logic [CHAR_W-1:0] digit_char,
    input logic              last_digit,
    input logic              radix_error
);

    // held result while stalled
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(digit_char)
            && $stable(last_digit) && $stable(radix_error))
        else $error("stalled result changed");

    // error transaction carries no digit
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && radix_error |-> (digit_char == '0) && !last_digit)
        else $error("error result carries a digit");

    // no new number while results are pending
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !in_ready)
        else $error("input taken while results pending");

    // string or error ends, block goes back to idle
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && (last_digit || radix_error) |=> !out_valid && in_ready)
        else $error("no return to idle after last transaction");

endmodule

bind radix_digit_string_converter_core rdsc_checker u_rdsc_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ready    (in_ready),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .digit_char  (digit_char),
    .last_digit  (last_digit),
    .radix_error (radix_error)
);

>>> sim/radix_digit_string_converter_core_tb.sv
// ----------------------------------------------------------------------------
// radix_digit_string_converter_core_tb
// self-checking bench: numbers go in on a valid/ready channel, each
// transaction's digit string is predicted in the configured radix and compared
// character by character, under sender idling, receiver stalls and radix
// changes between phases, bad radix values included
// ----------------------------------------------------------------------------
module radix_digit_string_converter_core_tb
    import rdsc_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int NUM_W       = NUMBER_WIDTH_DEF;
    localparam int DIGITS_MAX  = MAX_DIGITS_DEF;
    localparam int CYCLE_LIMIT = 1500000;
    localparam int HOLD_LEN    = 400;
    localparam int DRAIN_LEN   = 200;

    typedef struct packed {
        logic [CHAR_W-1:0] glyph;
        logic              last;
        logic              err;
    } digit_rec_t;

    logic               clk         = 1'b0;
    logic               rst_n       = 1'b0;
    logic               cfg_we      = 1'b0;
    logic [RADIX_W-1:0] cfg_wdata   = '0;
    logic               in_valid    = 1'b0;
    logic               in_ready;
    logic [NUM_W-1:0]   number      = '0;
    logic               out_valid;
    logic               out_ready   = 1'b0;
    logic [CHAR_W-1:0]  digit_char;
    logic               last_digit;
    logic               radix_error;

    logic [NUM_W-1:0]   number_q[$];
    digit_rec_t         digit_q[$];

    logic [RADIX_W-1:0] radix_reg = RADIX_RESET;
    logic [DIGIT_W-1:0] digit_store [DIGITS_MAX];
    int unsigned        digit_total = 0;
    logic [NUM_W-1:0]   quotient = '0;

    int unsigned        send_idle_pct  = 0;
    int unsigned        recv_stall_pct = 0;
    bit                 rx_hold_req    = 1'b0;
    int unsigned        rx_hold_left   = 0;
    bit                 number_taken   = 1'b0;
    int unsigned        mismatches     = 0;
    int unsigned        cycle_count    = 0;

    radix_digit_string_converter_core #(
        .NUMBER_WIDTH (NUM_W),
        .MAX_DIGITS   (DIGITS_MAX)
    ) dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .number      (number),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .digit_char  (digit_char),
        .last_digit  (last_digit),
        .radix_error (radix_error)
    );

    initial
    begin
        forever #1 clk = ~clk;
    end

    task automatic report_mismatch(input string what);
        if (mismatches < 50)
            $display("[%0t] mismatch: %s", $realtime, what);
        mismatches++;
    endtask

    // digit string of one number in the current radix, most significant first
    task automatic predict_digits(input logic [NUM_W-1:0] value);
        digit_rec_t         rec;
        int unsigned        k;
        logic [DIGIT_W-1:0] d;
        if (radix_reg < RADIX_MIN || radix_reg > RADIX_MAX)
        begin
            rec.glyph = '0;
            rec.last  = 1'b0;
            rec.err   = 1'b1;
            digit_q.push_back(rec);
        end
        else
        begin
            quotient    = value;
            digit_total = 0;
            do
            begin
                digit_store[digit_total] = DIGIT_W'(quotient % radix_reg);
                quotient = quotient / radix_reg;
                digit_total++;
            end
            while (quotient != 0 && digit_total < DIGITS_MAX);
            for (k = digit_total; k > 0; k--)
            begin
                d = digit_store[k - 1];
                if (d < DIGIT_W'(10))
                    rec.glyph = CHAR_ZERO + CHAR_W'(d);
                else
                    rec.glyph = CHAR_LETTER + CHAR_W'(d - DIGIT_W'(10));
                rec.last = (k == 1);
                rec.err  = 1'b0;
                digit_q.push_back(rec);
            end
        end
    endtask

    // waits until every number is taken and every character has come back
    task automatic wait_drained();
        do
            @(posedge clk);
        while (number_q.size() != 0 || in_valid || digit_q.size() != 0);
    endtask

    task automatic write_radix(input logic [RADIX_W-1:0] value);
        wait_drained();
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(negedge clk);
        cfg_we    <= 1'b0;
    endtask

    // number driver
    always @(negedge clk)
    begin
        if (!rst_n)
            in_valid <= 1'b0;
        else if (!in_valid || number_taken)
        begin
            if (number_q.size() != 0 && $urandom_range(99) >= send_idle_pct)
            begin
                in_valid <= 1'b1;
                number   <= number_q.pop_front();
            end
            else
                in_valid <= 1'b0;
        end
    end

    // digit receiver, with a long hold-off on request
    always @(negedge clk)
    begin
        if (rx_hold_req)
        begin
            rx_hold_left = HOLD_LEN;
            rx_hold_req  = 1'b0;
        end
        if (!rst_n)
            out_ready <= 1'b0;
        else if (rx_hold_left != 0)
        begin
            out_ready <= 1'b0;
            rx_hold_left--;
        end
        else
            out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // monitor and checker
    always @(posedge clk)
    begin
        digit_rec_t want;
        number_taken = rst_n && in_valid && in_ready;
        if (rst_n)
        begin
            if (cfg_we)
                radix_reg = cfg_wdata;
            if (number_taken)
                predict_digits(number);
            if (out_valid && out_ready)
            begin
                if (digit_q.size() == 0)
                    report_mismatch($sformatf("unexpected transaction char=%h last=%b err=%b",
                                              digit_char, last_digit, radix_error));
                else
                begin
                    want = digit_q.pop_front();
                    if (digit_char !== want.glyph)
                        report_mismatch($sformatf("digit_char %h, expected %h",
                                                  digit_char, want.glyph));
                    if (last_digit !== want.last)
                        report_mismatch($sformatf("last_digit %b, expected %b",
                                                  last_digit, want.last));
                    if (radix_error !== want.err)
                        report_mismatch($sformatf("radix_error %b, expected %b",
                                                  radix_error, want.err));
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    initial
    begin
        logic [NUM_W-1:0]   v;
        logic [RADIX_W-1:0] r;
        logic [63:0]        pw;
        int unsigned        mode;

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed: reset radix, extremes of radix and number, bad radix values
        send_idle_pct  = 12;
        recv_stall_pct = 12;
        number_q.push_back(32'd0);
        number_q.push_back(32'hFFFF_FFFF);
        number_q.push_back(32'd9);
        number_q.push_back(32'd10);
        number_q.push_back(32'd1_000_000_000);
        write_radix(6'd2);
        number_q.push_back(32'd0);
        number_q.push_back(32'd1);
        number_q.push_back(32'hFFFF_FFFF);
        number_q.push_back(32'h8000_0000);
        write_radix(6'd36);
        number_q.push_back(32'd35);
        number_q.push_back(32'd36);
        number_q.push_back(32'd1295);
        number_q.push_back(32'hFFFF_FFFF);
        write_radix(6'd0);
        number_q.push_back(32'd5);
        write_radix(6'd1);
        number_q.push_back(32'd0);
        write_radix(6'd37);
        number_q.push_back(32'd123);
        write_radix(6'd63);
        number_q.push_back(32'hFFFF_FFFF);
        write_radix(6'd16);
        number_q.push_back(32'hDEAD_BEEF);
        number_q.push_back(32'h0F0F_0F0F);

        // random phases
        for (int p = 0; p < 8; p++)
        begin
            mode = p % 4;
            if (p == 1)
                r = 6'd2;
            else if (p == 6)
                r = 6'd36;
            else if ($urandom_range(9) == 0)
                r = RADIX_W'($urandom_range(0, 63));
            else
                r = RADIX_W'($urandom_range(2, 36));
            write_radix(r);
            send_idle_pct  = (mode == 1) ? 87 : (mode == 3) ? 12 : 0;
            recv_stall_pct = (mode == 2) ? 87 : (mode == 3) ? 12 : 0;
            for (int i = 0; i < 18; i++)
            begin
                case ($urandom_range(4))
                    0: v = $urandom;
                    1: v = NUM_W'($urandom_range(0, 40));
                    2: v = $urandom >> $urandom_range(0, 31);
                    3: v = $urandom | 32'h8000_0000;
                    default:
                    begin
                        pw = 64'd1;
                        repeat ($urandom_range(1, 31))
                            if (pw * r < 64'h1_0000_0000)
                                pw = pw * r;
                        v = NUM_W'(pw - $urandom_range(0, 1));
                    end
                endcase
                number_q.push_back(v);
            end
            if (p == 4)
                rx_hold_req = 1'b1;
        end

        wait_drained();
        repeat (DRAIN_LEN) @(posedge clk);
        if (mismatches == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
